// ===== rtl/core/rvm_pkg.sv =====
// Shared constants, opcodes and state encoding for the register VM step block.
`default_nettype none
package rvm_pkg;

  // Byte memory size; must be a power of two so addresses wrap by masking.
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam int unsigned REG_COUNT = 16;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);
  localparam int unsigned WORD_W    = 16;

  typedef enum logic [3:0] {
    OP_HALT  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_NAND  = 4'd5,
    OP_SHL   = 4'd6,
    OP_SHR   = 4'd7,
    OP_IN    = 4'd8,
    OP_OUT   = 4'd9,
    OP_READ  = 4'd10,
    OP_WRITE = 4'd11,
    OP_LD16  = 4'd12,
    OP_ST16  = 4'd13,
    OP_LIT8  = 4'd14,
    OP_CPY   = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    BLK_NONE  = 2'd0,
    BLK_READ  = 2'd1,
    BLK_WRITE = 2'd2
  } blk_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OP,
    S_X1,
    S_LIT,
    S_B2,
    S_RX,
    S_RY,
    S_RZ,
    S_EXEC,
    S_DIV,
    S_L0,
    S_L1,
    S_S1,
    S_UPD
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/core/rvm_div.sv =====
// Iterative 16-bit unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module rvm_div
  import rvm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [WORD_W-1:0] dividend_i,
  input  wire logic [WORD_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [WORD_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(WORD_W + 1);

  logic [WORD_W-1:0] rem_q;
  logic [WORD_W-1:0] quo_q;
  logic [WORD_W-1:0] dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              run_q;
  logic              done_q;
  logic [WORD_W:0]   shifted;
  logic              fits;

  // A zero divisor always fits, so every quotient bit becomes one.
  assign shifted = {rem_q, quo_q[WORD_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(WORD_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? WORD_W'(shifted - {1'b0, dvs_q}) : shifted[WORD_W-1:0];
      quo_q <= {quo_q[WORD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== rtl/core/register_vm_instruction_step.sv =====
// Top level of the register VM: byte memory, register file, sequencer and result port.
// A load transaction and a step after halt report done in the cycle after acceptance;
// other instructions walk the sequencer states, paced by the single read port of the
// byte memory and register file and by the bit-per-cycle divider for DIV. One
// transaction is in flight at a time.
// Results are a one-cycle strobe on done_o; the receiver cannot stall them.
// Reset clears the PC, the halt state and the register valid bits; memory is not cleared.
`default_nettype none
module register_vm_instruction_step
  import rvm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        action_i,
  input  wire logic [15:0] load_address_i,
  input  wire logic [7:0]  load_data_i,
  input  wire logic [7:0]  in_char_i,
  input  wire logic        in_eof_i,
  output logic             done_o,
  output logic             in_taken_o,
  output logic             out_valid_o,
  output logic [7:0]       out_char_o,
  output logic             halted_o,
  output logic [15:0]      exit_code_o,
  output logic [1:0]       block_op_o,
  output logic [15:0]      block_first_o,
  output logic [15:0]      block_second_o,
  output logic [15:0]      block_third_o
);

  state_e state_q, state_d;

  // Architectural state outside the memories.
  logic [WORD_W-1:0]    pc_q;
  logic                 halt_q;
  logic [WORD_W-1:0]    halt_val_q;
  logic [REG_COUNT-1:0] vld_q;

  // Decoded instruction and operand latches.
  op_e               op_q;
  logic [REG_AW-1:0] x_q, y_q, z_q;
  logic [WORD_W-1:0] vx_q, vy_q, vz_q;
  logic [7:0]        lo_q;
  logic [7:0]        in_char_q;
  logic              in_eof_q;

  // Memory ports.
  logic [7:0]        mem [MEM_BYTES];
  logic [7:0]        mem_rd_q;
  logic              mem_we;
  logic [15:0]       mem_wa, mem_ra;
  logic [7:0]        mem_wd;
  logic [WORD_W-1:0] rf [REG_COUNT];
  logic [WORD_W-1:0] rf_rd_q;
  logic              rf_we;
  logic [REG_AW-1:0] rf_wa, rf_ra;
  logic [WORD_W-1:0] rf_wd;

  // Sequencer strobes and result fields.
  logic              pc_inc, halt_set, emit, div_start, div_done;
  logic [WORD_W-1:0] div_quo;
  logic              in_taken_d, out_valid_d;
  logic [7:0]        out_char_d;
  blk_e              block_op_d;
  logic [WORD_W-1:0] b1_d, b2_d, b3_d;
  logic [WORD_W-1:0] upd_a, upd_b, vy_inc;
  logic [7:0]        c_byte;

  logic              done_q, in_taken_q, out_valid_q;
  logic [7:0]        out_char_q;
  logic [1:0]        block_op_q;
  logic [WORD_W-1:0] b1_q, b2_q, b3_q;

  assign c_byte = mem_rd_q;
  assign vy_inc = vy_q + 16'd1;

  // LD16+ with z matching y or x: the post-increment sees the loaded word.
  assign upd_a = (op_q == OP_LD16 && y_q == z_q) ? vz_q : vy_q;
  assign upd_b = (op_q == OP_LD16 && x_q == z_q) ? vz_q : vx_q;

  rvm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (vy_q),
    .divisor_i  (vx_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_inc      = 1'b0;
    halt_set    = 1'b0;
    emit        = 1'b0;
    div_start   = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = load_address_i;
    mem_wd      = load_data_i;
    mem_ra      = pc_q;
    rf_we       = 1'b0;
    rf_wa       = z_q;
    rf_wd       = '0;
    rf_ra       = x_q;
    in_taken_d  = 1'b0;
    out_valid_d = 1'b0;
    out_char_d  = '0;
    block_op_d  = BLK_NONE;
    b1_d        = '0;
    b2_d        = '0;
    b3_d        = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (!action_i) begin
            mem_we = 1'b1;
            emit   = 1'b1;
          end else if (halt_q) begin
            emit = 1'b1;
          end else begin
            pc_inc  = 1'b1;
            state_d = S_OP;
          end
        end
      end
      S_OP: begin
        rf_ra = c_byte[3:0];
        case (op_e'(c_byte[7:4]))
          OP_HALT, OP_IN, OP_OUT: state_d = S_X1;
          OP_LIT8: begin
            pc_inc  = 1'b1;
            state_d = S_LIT;
          end
          default: begin
            pc_inc  = 1'b1;
            state_d = S_B2;
          end
        endcase
      end
      S_X1: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        case (op_q)
          OP_HALT: halt_set = 1'b1;
          OP_IN: begin
            rf_we      = 1'b1;
            rf_wa      = x_q;
            rf_wd      = in_eof_q ? 16'hFFFF : {8'h00, in_char_q};
            in_taken_d = 1'b1;
          end
          default: begin
            out_valid_d = 1'b1;
            out_char_d  = rf_rd_q[7:0];
          end
        endcase
      end
      S_LIT: begin
        rf_we   = 1'b1;
        rf_wa   = x_q;
        rf_wd   = {{8{c_byte[7]}}, c_byte};
        emit    = 1'b1;
        state_d = S_IDLE;
      end
      S_B2: begin
        rf_ra   = x_q;
        state_d = S_RX;
      end
      S_RX: begin
        rf_ra   = y_q;
        state_d = S_RY;
      end
      S_RY: begin
        rf_ra   = z_q;
        state_d = S_RZ;
      end
      S_RZ: state_d = S_EXEC;
      S_EXEC: begin
        emit    = 1'b1;
        state_d = S_IDLE;
        case (op_q)
          OP_ADD: begin
            rf_we = 1'b1;
            rf_wd = vy_q + vx_q;
          end
          OP_SUB: begin
            rf_we = 1'b1;
            rf_wd = vy_q - vx_q;
          end
          OP_MUL: begin
            rf_we = 1'b1;
            rf_wd = vy_q * vx_q;
          end
          OP_NAND: begin
            rf_we = 1'b1;
            rf_wd = ~(vy_q & vx_q);
          end
          OP_SHL: begin
            rf_we = 1'b1;
            rf_wd = (vx_q < 16'd16) ? (vy_q << vx_q[3:0]) : '0;
          end
          OP_SHR: begin
            rf_we = 1'b1;
            rf_wd = (vx_q < 16'd16) ? (vy_q >> vx_q[3:0]) : '0;
          end
          OP_CPY: begin
            rf_we = (vx_q == '0);
            rf_wd = vy_q;
          end
          OP_READ, OP_WRITE: begin
            block_op_d = (op_q == OP_READ) ? BLK_READ : BLK_WRITE;
            b1_d       = vz_q;
            b2_d       = vy_q;
            b3_d       = vx_q;
          end
          OP_DIV: begin
            emit      = 1'b0;
            div_start = 1'b1;
            state_d   = S_DIV;
          end
          OP_LD16: begin
            emit    = 1'b0;
            mem_ra  = vy_q;
            state_d = S_L0;
          end
          OP_ST16: begin
            emit    = 1'b0;
            mem_we  = 1'b1;
            mem_wa  = vy_q;
            mem_wd  = vz_q[7:0];
            state_d = S_S1;
          end
          default: emit = 1'b1;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          rf_we   = 1'b1;
          rf_wd   = div_quo;
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_L0: begin
        mem_ra  = vy_inc;
        state_d = S_L1;
      end
      S_L1: begin
        rf_we   = 1'b1;
        rf_wd   = {c_byte, lo_q};
        state_d = S_UPD;
      end
      S_S1: begin
        mem_we  = 1'b1;
        mem_wa  = vy_inc;
        mem_wd  = vz_q[15:8];
        state_d = S_UPD;
      end
      S_UPD: begin
        rf_we   = 1'b1;
        rf_wa   = y_q;
        rf_wd   = upd_a + upd_b;
        emit    = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Byte memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa[MEM_AW-1:0]] <= mem_wd;
    end
    mem_rd_q <= mem[mem_ra[MEM_AW-1:0]];
  end

  // Register file; register 0 is the PC and lives in its own flop.
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (rf_ra == '0) begin
      rf_rd_q <= pc_q;
    end else begin
      rf_rd_q <= vld_q[rf_ra] ? rf[rf_ra] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= '0;
      halt_q     <= 1'b0;
      halt_val_q <= '0;
      vld_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= emit;
      if (rf_we && rf_wa == '0) begin
        pc_q <= rf_wd;
      end else if (pc_inc) begin
        pc_q <= pc_q + 16'd1;
      end
      if (rf_we) begin
        vld_q[rf_wa] <= 1'b1;
      end
      if (halt_set) begin
        halt_q     <= 1'b1;
        halt_val_q <= rf_rd_q;
      end
    end
  end

  // Operand and result latches.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      in_char_q <= in_char_i;
      in_eof_q  <= in_eof_i;
    end
    if (state_q == S_OP) begin
      op_q <= op_e'(c_byte[7:4]);
      x_q  <= c_byte[3:0];
    end
    if (state_q == S_B2) begin
      y_q <= c_byte[7:4];
      z_q <= c_byte[3:0];
    end
    if (state_q == S_RX) vx_q <= rf_rd_q;
    if (state_q == S_RY) vy_q <= rf_rd_q;
    if (state_q == S_RZ) vz_q <= rf_rd_q;
    if (state_q == S_L0) lo_q <= c_byte;
    if (state_q == S_L1) vz_q <= {c_byte, lo_q};
    in_taken_q  <= in_taken_d;
    out_valid_q <= out_valid_d;
    out_char_q  <= out_char_d;
    block_op_q  <= block_op_d;
    b1_q        <= b1_d;
    b2_q        <= b2_d;
    b3_q        <= b3_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign in_taken_o     = in_taken_q;
  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign halted_o       = halt_q;
  assign exit_code_o    = halt_val_q;
  assign block_op_o     = block_op_q;
  assign block_first_o  = b1_q;
  assign block_second_o = b2_q;
  assign block_third_o  = b3_q;

endmodule
`default_nettype wire
